/* rtl/flag_frame_unstuff_checksum_unit_macros.svh */
// Assertion helpers shared by the receiver modules.
`ifndef FLAG_FRAME_UNSTUFF_CHECKSUM_UNIT_MACROS_SVH
`define FLAG_FRAME_UNSTUFF_CHECKSUM_UNIT_MACROS_SVH

// Check that a condition never occurs while out of reset.
`define FFCS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define FFCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/ffcs_pkg.sv */
`timescale 1ns / 1ps
package ffcs_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
  localparam logic [7:0] SUM_START    = 8'd4;
  localparam logic [7:0] CHECK_POS    = 8'd1;

  // Raw byte count of a frame never exceeds 256.
  localparam int unsigned RAW_W = 9;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       frame_end;
    logic       checksum_ok;
    logic       frame_abort;
  } res_t;

  // One input transaction's worth of results: one or two.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/ffcs_front.sv */
`timescale 1ns / 1ps
`include "flag_frame_unstuff_checksum_unit_macros.svh"
module ffcs_front #(
  parameter int unsigned FRAME_LIMIT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            rx_overflow_i,
  output logic            push_o,
  output ffcs_pkg::entry_t entry_o
);
  import ffcs_pkg::*;

  logic             in_frame_q, in_frame_d;
  logic             esc_q, esc_d;
  logic [RAW_W-1:0] raw_q, raw_d;
  logic [7:0]       pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       chk_q, chk_d;
  logic [1:0]       n_res;
  res_t             r0, r1, x;
  logic             handle, hunt;
  logic [7:0]       e_data;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    raw_d      = raw_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    n_res      = 2'd0;
    r0         = '0;
    r1         = '0;
    x          = '0;
    handle     = 1'b0;
    hunt       = 1'b0;
    e_data     = ESC_BYTE;
    if (rx_overflow_i) begin
      if (in_frame_q) begin
        r0.frame_abort = 1'b1;
        n_res          = 2'd1;
      end
      hunt = 1'b1;
    end else if (!in_frame_q) begin
      if (rx_byte_i == FLAG_BYTE) begin
        in_frame_d   = 1'b1;
        esc_d        = 1'b0;
        raw_d        = RAW_W'(1);
        pos_d        = 8'd1;
        sum_d        = '0;
        chk_d        = '0;
        r0.data_byte = FLAG_BYTE;
        n_res        = 2'd1;
      end
    end else if (raw_q >= RAW_W'(FRAME_LIMIT)) begin
      r0.frame_abort = 1'b1;
      n_res          = 2'd1;
      hunt           = 1'b1;
    end else begin
      raw_d  = raw_q + RAW_W'(1);
      handle = 1'b1;
      if (esc_q) begin
        esc_d = 1'b0;
        if (rx_byte_i == ESC_FOR_FLAG) begin
          e_data = FLAG_BYTE;
        end
        if (rx_byte_i == ESC_FOR_ESC || rx_byte_i == ESC_FOR_FLAG) begin
          handle = 1'b0;
        end
        if (pos_d == CHECK_POS) begin
          chk_d = e_data;
        end
        if (pos_d >= SUM_START) begin
          sum_d = sum_d + e_data;
        end
        r0.data_byte  = e_data;
        r0.byte_index = pos_d;
        n_res         = 2'd1;
        pos_d         = pos_d + 8'd1;
      end
      if (handle) begin
        if (rx_byte_i == FLAG_BYTE) begin
          if (pos_d == CHECK_POS) begin
            chk_d = FLAG_BYTE;
          end
          x.data_byte   = FLAG_BYTE;
          x.byte_index  = pos_d;
          x.frame_end   = 1'b1;
          x.checksum_ok = (sum_d == chk_d);
          if (n_res == 2'd0) begin
            r0 = x;
          end else begin
            r1 = x;
          end
          n_res = n_res + 2'd1;
          hunt  = 1'b1;
        end else if (rx_byte_i == ESC_BYTE) begin
          esc_d = 1'b1;
        end else begin
          if (pos_d == CHECK_POS) begin
            chk_d = rx_byte_i;
          end
          if (pos_d >= SUM_START) begin
            sum_d = sum_d + rx_byte_i;
          end
          x.data_byte  = rx_byte_i;
          x.byte_index = pos_d;
          if (n_res == 2'd0) begin
            r0 = x;
          end else begin
            r1 = x;
          end
          n_res = n_res + 2'd1;
          pos_d = pos_d + 8'd1;
        end
      end
    end
    if (hunt) begin
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
      raw_d      = '0;
      pos_d      = '0;
      sum_d      = '0;
      chk_d      = '0;
    end
  end

  assign push_o   = accept_i && (n_res != 2'd0);
  assign entry_o  = '{two: (n_res == 2'd2), r0: r0, r1: r1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      raw_q      <= '0;
      pos_q      <= '0;
      sum_q      <= '0;
      chk_q      <= '0;
    end else if (accept_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      raw_q      <= raw_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      chk_q      <= chk_d;
    end
  end

  `FFCS_ASSERT_IMP(a_esc_in_frame, esc_q, in_frame_q, "escape pending outside a frame")
  `FFCS_ASSERT_NEVER(a_raw_limit, raw_q > RAW_W'(FRAME_LIMIT), "raw count beyond frame limit")

endmodule

/* rtl/ffcs_fifo.sv */
`timescale 1ns / 1ps
`include "flag_frame_unstuff_checksum_unit_macros.svh"
module ffcs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ffcs_pkg::entry_t    push_data_i,
  input  logic                pop_i,
  output ffcs_pkg::entry_t    pop_data_o,
  output ffcs_pkg::q_status_t status_o
);
  import ffcs_pkg::*;

  entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  `FFCS_ASSERT_NEVER(a_no_overrun, push_i && status_o.full, "push into full queue")
  `FFCS_ASSERT_NEVER(a_no_underrun, pop_i && status_o.empty, "pop from empty queue")

endmodule

/* rtl/ffcs_back.sv */
`timescale 1ns / 1ps
`include "flag_frame_unstuff_checksum_unit_macros.svh"
module ffcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffcs_pkg::entry_t    entry_i,
  input  ffcs_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ffcs_pkg::res_t      res_o,
  output logic                last_o
);
  import ffcs_pkg::*;

  logic out_valid_q;
  res_t out_q;
  logic last_q;
  logic pend_valid_q;
  res_t pend_q;
  logic can_load;

  assign can_load = !out_valid_q || out_ready_i;
  assign pop_o    = can_load && !pend_valid_q && !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      last_q       <= 1'b0;
      pend_q       <= '0;
    end else if (can_load) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        out_q        <= pend_q;
        last_q       <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (!q_status_i.empty) begin
        out_valid_q  <= 1'b1;
        out_q        <= entry_i.r0;
        last_q       <= !entry_i.two;
        pend_valid_q <= entry_i.two;
        pend_q       <= entry_i.r1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign last_o      = last_q;

  `FFCS_ASSERT_IMP(a_pend_behind_out, pend_valid_q, out_valid_q && !last_q,
                   "second result held without a first one in front")

endmodule

/* rtl/flag_frame_unstuff_checksum_unit.sv */
`timescale 1ns / 1ps
// A transaction enters the queue at its accepting edge; its first result is then
// loaded into the output register once that register can load and no earlier
// second result is pending. Throughput: one input per cycle while results flow;
// a transaction with two results holds the output for both in turn, and the
// 4-entry queue absorbs bursts. Reset: rst_ni asynchronous, active low; clears
// frame state, queue and output, and the unit starts hunting for an opening flag.
module flag_frame_unstuff_checksum_unit #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_overflow_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_index_o,
  output logic       frame_end_o,
  output logic       checksum_ok_o,
  output logic       frame_abort_o,
  output logic       last_o
);
  import ffcs_pkg::*;

  // Raw frame length is capped at 256 so byte_index always fits in 8 bits.
  localparam int unsigned FRAME_LIMIT = (MAX_FRAME < 256) ? MAX_FRAME : 256;

  logic      accept;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head_entry;
  q_status_t q_status;
  res_t      res;

  // Take a new transaction whenever the queue has room; the back end drains
  // independently, so a stalled consumer only blocks input once the queue fills.
  assign in_ready_o = !q_status.full;
  assign accept     = in_valid_i && in_ready_o;

  // Front: hunt for flags, strip escapes, track index and checksum, and
  // bundle the one or two results of each transaction.
  ffcs_front #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .rx_overflow_i(rx_overflow_i),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Queue: decouple classification from result delivery.
  ffcs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .pop_i      (pop),
    .pop_data_o (head_entry),
    .status_o   (q_status)
  );

  // Back: serialize each bundle into results through the output register,
  // marking the final one of the transaction.
  ffcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head_entry),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res),
    .last_o     (last_o)
  );

  assign data_byte_o   = res.data_byte;
  assign byte_index_o  = res.byte_index;
  assign frame_end_o   = res.frame_end;
  assign checksum_ok_o = res.checksum_ok;
  assign frame_abort_o = res.frame_abort;

endmodule

/* sim/flag_frame_unstuff_checksum_unit_checker.sv */
`timescale 1ns / 1ps
module flag_frame_unstuff_checksum_unit_checker #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_overflow_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] byte_index_i,
  input  logic       frame_end_i,
  input  logic       checksum_ok_i,
  input  logic       frame_abort_i,
  input  logic       last_i,
  input  logic       end_check_i,
  output int         err_cnt_o,
  output int         pending_o,
  output int         closed_cnt_o,
  output int         sum_match_cnt_o,
  output int         abort_cnt_o
);
  import ffcs_pkg::*;

  localparam int unsigned FRAME_LIMIT = (MAX_FRAME < 256) ? MAX_FRAME : 256;

  typedef struct packed {
    res_t res;
    logic last;
  } frame_res_t;

  // Model of the receiver state.
  logic        in_frame_q;
  logic        esc_pend_q;
  int unsigned raw_cnt_q;
  logic [7:0]  pos_q;
  logic [7:0]  sum_q;
  logic [7:0]  check_q;

  frame_res_t step_res_q[$];
  frame_res_t unstuffed_q[$];

  initial begin
    err_cnt_o       = 0;
    pending_o       = 0;
    closed_cnt_o    = 0;
    sum_match_cnt_o = 0;
    abort_cnt_o     = 0;
  end

  task automatic flag_error(input string msg);
    if (err_cnt_o < 100) $display("ERROR @%0t: %s", $time, msg);
    err_cnt_o++;
  endtask

  function automatic void resume_hunt();
    in_frame_q = 1'b0;
    esc_pend_q = 1'b0;
    raw_cnt_q  = 0;
    pos_q      = 8'h00;
    sum_q      = 8'h00;
    check_q    = 8'h00;
  endfunction

  function automatic void push_res(input logic [7:0] d, input logic [7:0] idx,
                                   input logic fend, input logic ok, input logic ab);
    frame_res_t r;
    r.res.data_byte   = d;
    r.res.byte_index  = idx;
    r.res.frame_end   = fend;
    r.res.checksum_ok = ok;
    r.res.frame_abort = ab;
    r.last            = 1'b0;
    step_res_q.push_back(r);
  endfunction

  // Emit one unescaped data byte and fold it into the check fields.
  function automatic void emit_data(input logic [7:0] d);
    if (pos_q == CHECK_POS) check_q = d;
    if (pos_q >= SUM_START) sum_q = sum_q + d;
    push_res(d, pos_q, 1'b0, 1'b0, 1'b0);
    pos_q = pos_q + 8'd1;
  endfunction

  function automatic void unstuff_byte(input logic [7:0] b, input logic ovf);
    logic handle;
    handle = 1'b1;
    step_res_q.delete();
    if (ovf) begin
      if (in_frame_q) push_res(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
      resume_hunt();
    end else if (!in_frame_q) begin
      if (b == FLAG_BYTE) begin
        resume_hunt();
        in_frame_q = 1'b1;
        raw_cnt_q  = 1;
        pos_q      = 8'd1;
        push_res(FLAG_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
      end
    end else if (raw_cnt_q >= FRAME_LIMIT) begin
      push_res(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
      resume_hunt();
    end else begin
      raw_cnt_q++;
      if (esc_pend_q) begin
        esc_pend_q = 1'b0;
        if (b == ESC_FOR_ESC) begin
          emit_data(ESC_BYTE);
          handle = 1'b0;
        end else if (b == ESC_FOR_FLAG) begin
          emit_data(FLAG_BYTE);
          handle = 1'b0;
        end else begin
          emit_data(ESC_BYTE);
        end
      end
      if (handle) begin
        if (b == FLAG_BYTE) begin
          // a close at position 1 doubles as the check byte
          if (pos_q == CHECK_POS) check_q = FLAG_BYTE;
          push_res(FLAG_BYTE, pos_q, 1'b1, sum_q == check_q, 1'b0);
          resume_hunt();
        end else if (b == ESC_BYTE) begin
          esc_pend_q = 1'b1;
        end else begin
          emit_data(b);
        end
      end
    end
    if (step_res_q.size() > 0) step_res_q[step_res_q.size() - 1].last = 1'b1;
    foreach (step_res_q[i]) unstuffed_q.push_back(step_res_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_res_t want;
    frame_res_t got;
    if (!rst_ni) begin
      resume_hunt();
      unstuffed_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) unstuff_byte(rx_byte_i, rx_overflow_i);
      if (out_valid_i && out_ready_i) begin
        got.res.data_byte   = data_byte_i;
        got.res.byte_index  = byte_index_i;
        got.res.frame_end   = frame_end_i;
        got.res.checksum_ok = checksum_ok_i;
        got.res.frame_abort = frame_abort_i;
        got.last            = last_i;
        if (unstuffed_q.size() == 0) begin
          flag_error($sformatf("unexpected result %h", got));
        end else begin
          want = unstuffed_q.pop_front();
          if (got.res.data_byte !== want.res.data_byte)
            flag_error($sformatf("data_byte %h, want %h",
                                 got.res.data_byte, want.res.data_byte));
          if (got.res.byte_index !== want.res.byte_index)
            flag_error($sformatf("byte_index %h, want %h",
                                 got.res.byte_index, want.res.byte_index));
          if (got.res.frame_end !== want.res.frame_end)
            flag_error($sformatf("frame_end %b, want %b",
                                 got.res.frame_end, want.res.frame_end));
          if (got.res.checksum_ok !== want.res.checksum_ok)
            flag_error($sformatf("checksum_ok %b, want %b",
                                 got.res.checksum_ok, want.res.checksum_ok));
          if (got.res.frame_abort !== want.res.frame_abort)
            flag_error($sformatf("frame_abort %b, want %b",
                                 got.res.frame_abort, want.res.frame_abort));
          if (got.last !== want.last)
            flag_error($sformatf("last %b, want %b", got.last, want.last));
          if (want.res.frame_end) closed_cnt_o++;
          if (want.res.frame_end && want.res.checksum_ok) sum_match_cnt_o++;
          if (want.res.frame_abort) abort_cnt_o++;
        end
      end
    end
    pending_o = unstuffed_q.size();
  end

  always @(posedge end_check_i) begin
    if (unstuffed_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", unstuffed_q.size()));
  end

endmodule

/* sim/flag_frame_unstuff_checksum_unit_test.sv */
`timescale 1ns / 1ps
module flag_frame_unstuff_checksum_unit_test;
  import ffcs_pkg::*;

  localparam int unsigned MAX_FRAME    = 256;
  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       rx_overflow_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic       frame_end_o;
  logic       checksum_ok_o;
  logic       frame_abort_o;
  logic       last_o;
  logic       end_check;

  int err_cnt;
  int pending;
  int closed_cnt;
  int sum_match_cnt;
  int abort_cnt;

  // Percent chances per cycle: sender gap and receiver stall.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  // Long receiver hold-off, requested by the stimulus and counted by the receiver.
  int unsigned hold_req  = 0;

  int unsigned items_sent = 0;
  int unsigned noise_sent = 0;

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  flag_frame_unstuff_checksum_unit #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .rx_overflow_i(rx_overflow_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .frame_end_o  (frame_end_o),
    .checksum_ok_o(checksum_ok_o),
    .frame_abort_o(frame_abort_o),
    .last_o       (last_o)
  );

  flag_frame_unstuff_checksum_unit_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .rx_overflow_i  (rx_overflow_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_i    (data_byte_o),
    .byte_index_i   (byte_index_o),
    .frame_end_i    (frame_end_o),
    .checksum_ok_i  (checksum_ok_o),
    .frame_abort_i  (frame_abort_o),
    .last_i         (last_o),
    .end_check_i    (end_check),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending),
    .closed_cnt_o   (closed_cnt),
    .sum_match_cnt_o(sum_match_cnt),
    .abort_cnt_o    (abort_cnt)
  );

  // Receiver: decide ready at each falling edge. A pending hold request
  // drops ready until its hold count runs out; otherwise stall at stall_pct.
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one byte: idle for a random gap first, then hold valid and the
  // payload steady until the transaction completes. Valid stays high on
  // exit so back-to-back bytes need no bubble.
  task automatic send_item(input logic [7:0] b, input logic ovf);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    rx_overflow_i <= ovf;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  // Favor the bytes that steer the unstuffer.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return ESC_FOR_ESC;
      3:       return ESC_FOR_FLAG;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Build one unescaped frame body, optionally with a matching checksum in
  // byte 1, then stuff it and send it between flags. Plain frames draw no
  // random flag or escape bytes and always send a closing flag; others may
  // get stray escapes and may end in an overflow or be cut short.
  task automatic send_frame(input int unsigned n_data, input bit plain);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [7:0]  total;
    int unsigned ending;
    total = 8'h00;
    for (int i = 0; i < n_data; i++) begin
      if (plain) begin
        do b = 8'($urandom_range(255)); while (b == FLAG_BYTE || b == ESC_BYTE);
      end else begin
        b = pick_byte();
      end
      body.push_back(b);
      if (i >= 3) total = total + b;
    end
    if (n_data > 0 && $urandom_range(1)) body[0] = total;

    send_item(FLAG_BYTE, 1'b0);
    foreach (body[i]) begin
      if (!plain && $urandom_range(19) == 0) send_item(ESC_BYTE, 1'b0);
      if (body[i] == FLAG_BYTE) begin
        send_item(ESC_BYTE, 1'b0);
        send_item(ESC_FOR_FLAG, 1'b0);
      end else if (body[i] == ESC_BYTE) begin
        send_item(ESC_BYTE, 1'b0);
        send_item(ESC_FOR_ESC, 1'b0);
      end else begin
        send_item(body[i], 1'b0);
      end
    end

    ending = plain ? 0 : $urandom_range(99);
    if (ending < 85) begin
      // Escape right before the close: 0x7D comes out, then the flag.
      if (!plain && $urandom_range(15) == 0) send_item(ESC_BYTE, 1'b0);
      send_item(FLAG_BYTE, 1'b0);
    end else if (ending < 93) begin
      send_item(pick_byte(), 1'b1);
    end
    // else cut short: the next opening flag closes this frame instead, unless an overflow in noise aborts it first
  endtask

  // Line noise between frames, dropped while hunting.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(3) == 0) begin
        send_item(pick_byte(), 1'b1);
      end else begin
        do b = pick_byte(); while (b == FLAG_BYTE);
        send_item(b, 1'b0);
      end
      noise_sent++;
    end
  endtask

  // Directed bytes: {overflow, byte}.
  logic [8:0] directed_seq[] = '{
    // Hunting: noise at both extremes, overflow on a flag.
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b1, FLAG_BYTE},
    // Flag closing at position 1, which also serves as the check byte.
    {1'b0, FLAG_BYTE}, {1'b0, FLAG_BYTE},
    // Escaped escape, escaped flag, escape before data, escape before
    // escape, escape before the closing flag.
    {1'b0, FLAG_BYTE}, {1'b0, ESC_BYTE}, {1'b0, ESC_FOR_ESC},
    {1'b0, ESC_BYTE}, {1'b0, ESC_FOR_FLAG}, {1'b0, ESC_BYTE}, {1'b0, 8'hFF},
    {1'b0, 8'h00}, {1'b0, ESC_BYTE}, {1'b0, ESC_BYTE}, {1'b0, FLAG_BYTE},
    // Matching checksum: byte 1 equals the sum from position 4.
    {1'b0, FLAG_BYTE}, {1'b0, 8'h80}, {1'b0, 8'h11}, {1'b0, 8'h22},
    {1'b0, 8'h80}, {1'b0, FLAG_BYTE},
    // Overflow inside a frame.
    {1'b0, FLAG_BYTE}, {1'b0, 8'h33}, {1'b1, 8'h44}
  };

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = 8'h00;
    rx_overflow_i = 1'b0;
    end_check     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_seq[i]) send_item(directed_seq[i][7:0], directed_seq[i][8]);

    // Four idle phases: none, sender gaps, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase

      // Largest frames: one closing at the top index, one running past the
      // raw byte limit so that its closing flag aborts it instead.
      if (ph == 0) send_frame(MAX_FRAME - 2, 1'b1);
      if (ph == 3) send_frame(MAX_FRAME - 1, 1'b1);

      // Hold the receiver off while bytes keep coming, so the result
      // queue fills and input ready drops.
      if (ph == 1) hold_req++;

      while (items_sent - noise_sent < (ph + 1) * ITEM_TARGET / 4) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_frame(n, 1'b0);
        if ($urandom_range(4) == 0) send_noise();
      end

      // Let the block run dry once before the last phase.
      if (ph == 2) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    end_check = 1'b1;
    #1;
    $display("Sent %0d bytes (%0d noise) across four idle phases and one long stall.",
             items_sent, noise_sent);
    $display("Frames closed: %0d, checksum matches: %0d, aborts: %0d.",
             closed_cnt, sum_match_cnt, abort_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #4_000_000;
    $display("Timeout: the run did not finish.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ffcs_pkg.sv
rtl/ffcs_front.sv
rtl/ffcs_fifo.sv
rtl/ffcs_back.sv
rtl/flag_frame_unstuff_checksum_unit.sv
sim/flag_frame_unstuff_checksum_unit_checker.sv
sim/flag_frame_unstuff_checksum_unit_test.sv
